// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define PX_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define PX_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PX_ASSERT(lbl, clk, rst_n, prop, msg)
`define PX_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hdl/pxat_pkg.sv =====
// types and constants of the paxos acceptor table
package pxat_pkg;

	localparam int PXAT_NUM_RESOURCES = 16;
	localparam int PXAT_BALLOT_BITS   = 32;
	localparam int PXAT_ACTION_BITS   = 8;

	// resource ids the request word can carry
	localparam int PXAT_RID_SPAN = 16;

	typedef enum logic {
		OP_PREPARE = 1'b0,
		OP_ACCEPT  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_PROMISE     = 2'd0,
		KIND_PROMISE_VAL = 2'd1,
		KIND_ACCEPTED    = 2'd2
	} kind_t;

	typedef struct packed {
		op_t         operation;
		logic [3:0]  resource_id;
		logic [31:0] ballot;
		logic [7:0]  action_in;
		logic [15:0] client_port_in;
		logic [7:0]  verdict_in;
		logic [15:0] sender_address;
	} req_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  resource_out;
		logic [31:0] ballot_out;
		logic [7:0]  action_out;
		logic [15:0] client_port_out;
		logic [7:0]  verdict_out;
		logic [15:0] destination;
		logic        is_broadcast;
	} rsp_word_t;

	// table verdict for the word under decision
	typedef struct packed {
		logic      emit;
		rsp_word_t word;
	} tbl_res_t;

endpackage

// ===== hdl/pxat_table.sv =====
// per-resource promise and accept state with the combinational decision
`include "assert_macros.svh"

module pxat_table import pxat_pkg::*; #(
	parameter int NUM_RESOURCES = PXAT_NUM_RESOURCES,
	parameter int BALLOT_BITS   = PXAT_BALLOT_BITS,
	parameter int ACTION_BITS   = PXAT_ACTION_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      commit,
	input  req_word_t req,
	output tbl_res_t  res
);

	// only ids the request word can carry need storage
	localparam int DEPTH    = (NUM_RESOURCES < PXAT_RID_SPAN) ? NUM_RESOURCES : PXAT_RID_SPAN;
	localparam int IDX_BITS = $clog2(DEPTH);

	logic                   pv_q [DEPTH];
	logic [BALLOT_BITS-1:0] pb_q [DEPTH];
	logic                   av_q [DEPTH];
	logic [ACTION_BITS-1:0] aa_q [DEPTH];

	logic [8:0]             rid_w;
	logic                   rid_ok;
	logic [IDX_BITS-1:0]    idx;
	logic [63:0]            bal_w;
	logic [BALLOT_BITS-1:0] bal;
	logic [31:0]            act_w;
	logic [ACTION_BITS-1:0] act;
	logic                   pv;
	logic [BALLOT_BITS-1:0] pb;
	logic                   av;
	logic [ACTION_BITS-1:0] aa;
	logic                   pass;
	logic                   is_acc;

	// narrow the request fields to the stored widths
	assign rid_w  = 9'(req.resource_id);
	assign rid_ok = rid_w < 9'(NUM_RESOURCES);
	assign idx    = rid_w[IDX_BITS-1:0];
	assign bal_w  = 64'(req.ballot);
	assign bal    = bal_w[BALLOT_BITS-1:0];
	assign act_w  = 32'(req.action_in);
	assign act    = act_w[ACTION_BITS-1:0];
	assign is_acc = (req.operation == OP_ACCEPT);

	// entry read
	assign pv = pv_q[idx];
	assign pb = pb_q[idx];
	assign av = av_q[idx];
	assign aa = aa_q[idx];

	// prepare needs a strictly higher ballot, accept an equal or higher one
	always_comb begin
		if (is_acc) begin
			pass = !pv || !(pb > bal);
		end else begin
			pass = !pv || (pb < bal);
		end
	end

	// result word
	always_comb begin
		res.emit                 = rid_ok && pass;
		res.word.resource_out    = req.resource_id;
		res.word.ballot_out      = 32'(bal);
		if (is_acc) begin
			res.word.kind            = KIND_ACCEPTED;
			res.word.action_out      = 8'(act);
			res.word.client_port_out = req.client_port_in;
			res.word.verdict_out     = req.verdict_in;
			res.word.destination     = '0;
			res.word.is_broadcast    = 1'b1;
		end else begin
			res.word.kind            = av ? KIND_PROMISE_VAL : KIND_PROMISE;
			res.word.action_out      = av ? 8'(aa) : 8'd0;
			res.word.client_port_out = '0;
			res.word.verdict_out     = '0;
			res.word.destination     = req.sender_address;
			res.word.is_broadcast    = 1'b0;
		end
	end

	// valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				pv_q[i] <= 1'b0;
				av_q[i] <= 1'b0;
			end
		end else if (commit && res.emit) begin
			pv_q[idx] <= 1'b1;
			if (is_acc) begin
				av_q[idx] <= 1'b1;
			end
		end
	end

	// ballot and action store, guarded by the valid marks
	always_ff @(posedge clk) begin
		if (commit && res.emit) begin
			pb_q[idx] <= bal;
			if (is_acc) begin
				aa_q[idx] <= act;
			end
		end
	end

	`PX_NEVER(a_emit_range, clk, arst_n, commit && res.emit && !rid_ok, "result for unknown resource")
	`PX_ASSERT(a_prom_set, clk, arst_n, commit && res.emit |=> pv_q[$past(idx)], "promise not stored")
	`PX_ASSERT(a_acc_set, clk, arst_n, commit && res.emit && is_acc |=> av_q[$past(idx)], "accept not stored")

endmodule

// ===== hdl/paxos_acceptor_table_top.sv =====
// Paxos acceptor table: one request word a cycle, at most one reply word each.
// A request is registered on acceptance, decided against the per-resource
// promise/accept registers in the following cycle and written back when it
// leaves the input register, and its reply (if any) is loaded into an output
// register as it leaves, raising rsp_valid. One word per cycle is sustained
// while no reply stalls the input, since the resource register table is read
// and compared combinationally; while a reply waits unaccepted, a request that
// would give a reply holds the input. Requests for resources at or above
// NUM_RESOURCES and rejected requests give no reply and change nothing.
`include "assert_macros.svh"

module paxos_acceptor_table_top import pxat_pkg::*; #(
	parameter int NUM_RESOURCES = PXAT_NUM_RESOURCES,
	parameter int BALLOT_BITS   = PXAT_BALLOT_BITS,
	parameter int ACTION_BITS   = PXAT_ACTION_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	logic      valid_s1;
	req_word_t req_s1;
	logic      valid_s2;
	rsp_word_t rsp_s2;
	tbl_res_t  res;
	logic      adv_s1;

	pxat_table #(
		.NUM_RESOURCES (NUM_RESOURCES),
		.BALLOT_BITS   (BALLOT_BITS),
		.ACTION_BITS   (ACTION_BITS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (adv_s1),
		.req    (req_s1),
		.res    (res)
	);

	// stage 1 moves on when its reply has room or there is no reply
	assign adv_s1    = valid_s1 && (!valid_s2 || rsp_ready || !res.emit);
	assign req_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && res.emit) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.emit) begin
			rsp_s2 <= res.word;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	`PX_NEVER(a_no_overwrite, clk, arst_n, valid_s2 && !rsp_ready && adv_s1 && res.emit, "reply overwritten")
	`PX_ASSERT(a_ready_empty, clk, arst_n, !valid_s1 |-> req_ready, "not ready while empty")
	`PX_ASSERT(a_reply_follows, clk, arst_n, adv_s1 && res.emit |=> valid_s2, "reply lost")

endmodule
